// ===== sv/sdws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed duty waveform sampler: shared definitions
// Widths, register indexes, the fixed window table and the sequencer types.
// ----------------------------------------------------------------------------
package sdws_pkg;

  // Period and window geometry; the window table below belongs to this period
  localparam int PERIOD_SAMPLES = 100;
  localparam int HALF_W         = PERIOD_SAMPLES / 10;
  localparam int TAP_LAST       = 2 * HALF_W;
  localparam int POS_W          = $clog2(PERIOD_SAMPLES + 1);
  localparam int TAP_W          = $clog2(HALF_W + 1);
  localparam int CNT_W          = $clog2(TAP_LAST + 1);

  // Field and register widths
  localparam int INDEX_W   = 7;
  localparam int OUT_W     = 16;
  localparam int AMP_W     = 16;
  localparam int DUTY_W    = 17;
  localparam int PHASE_W   = 16;
  localparam int DATA_W    = 17;
  localparam int REG_IDX_W = 2;
  localparam int FRAC_BITS = 16;

  // Arithmetic
  localparam int WEIGHT_W   = 16;
  localparam int WEIGHT_SUM = 32769;
  localparam int ACC_W      = 17;
  localparam int PROD_W     = AMP_W + ACC_W;
  localparam int Q_SHIFT    = 15;
  localparam int ROUND_HALF = 1 << (Q_SHIFT - 1);
  localparam int SAT_MAX    = 32767;
  localparam int SAT_NEG    = 32768;

  // Reset values of the configuration registers
  localparam logic signed [AMP_W-1:0] AMP_RESET   = 16'sd4096;
  localparam logic [DUTY_W-1:0]       DUTY_RESET  = 17'd32768;
  localparam logic [PHASE_W-1:0]      PHASE_RESET = 16'd0;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DUTY      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TAP,
    ST_MUL,
    ST_RND
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic             high;
    logic [TAP_W-1:0] tap;
  } acc_ctl_t;

  // Normalised Gaussian window, Q0.15, taps 0..HALF_W (symmetric)
  function automatic logic [WEIGHT_W-1:0] window_weight(input logic [TAP_W-1:0] tap);
    logic [WEIGHT_W-1:0] w;
    case (tap)
      4'd0:    w = 16'd4359;
      4'd1:    w = 16'd4124;
      4'd2:    w = 16'd3491;
      4'd3:    w = 16'd2644;
      4'd4:    w = 16'd1792;
      4'd5:    w = 16'd1087;
      4'd6:    w = 16'd590;
      4'd7:    w = 16'd287;
      4'd8:    w = 16'd125;
      4'd9:    w = 16'd48;
      4'd10:   w = 16'd17;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/sdws_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window accumulator
// Shared add/subtract unit: one window tap per cycle, weight from the ROM.
// ----------------------------------------------------------------------------
module sdws_accum (
  input  logic                               clk,
  input  sdws_pkg::acc_ctl_t                 ctl,
  output logic signed [sdws_pkg::ACC_W-1:0]  acc
);
  import sdws_pkg::*;

  logic signed [ACC_W-1:0] weight;
  logic signed [ACC_W-1:0] acc_next;

  assign weight = signed'(ACC_W'(window_weight(ctl.tap)));

  always_comb begin
    acc_next = acc;
    if (ctl.clear) begin
      acc_next = '0;
    end else if (ctl.step) begin
      // add the weight where the square wave is high, subtract where low
      acc_next = ctl.high ? acc + weight : acc - weight;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

// ===== sv/sdws_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amplitude scaler
// Registered amplitude product, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module sdws_scale (
  input  logic                               clk,
  input  logic                               load,
  input  logic signed [sdws_pkg::AMP_W-1:0]  amp,
  input  logic signed [sdws_pkg::ACC_W-1:0]  acc,
  output logic signed [sdws_pkg::OUT_W-1:0]  rounded
);
  import sdws_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic        [PROD_W-1:0] mag;
  logic        [PROD_W-1:0] q;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(amp) * PROD_W'(acc);
    end
  end

  always_comb begin
    mag = prod[PROD_W-1] ? unsigned'(-prod) : unsigned'(prod);
    q   = (mag + PROD_W'(ROUND_HALF)) >> Q_SHIFT;
    if (prod[PROD_W-1]) begin
      if (q >= PROD_W'(SAT_NEG)) begin
        rounded = signed'(OUT_W'(SAT_NEG));
      end else begin
        rounded = signed'(OUT_W'(-q));
      end
    end else begin
      if (q > PROD_W'(SAT_MAX)) begin
        rounded = signed'(OUT_W'(SAT_MAX));
      end else begin
        rounded = signed'(OUT_W'(q));
      end
    end
  end

endmodule

// ===== sv/smoothed_duty_waveform_sampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed duty waveform sampler
// Square wave of set duty, smoothed by a fixed Gaussian window, phased and
// scaled by amplitude; one smoothed sample returned per requested index.
// ----------------------------------------------------------------------------
// Each index beat runs through a setup step, an accumulate step per window tap
// (through a single shared adder), a multiply step and a round step that
// writes the output register. index_stall is high from the setup step through
// the round step, so no new index is taken before the last one is done. A result
// waiting in the output register does not block a new index; only the round step
// waits for the slot to free. The window is fixed for a period of 100 samples.
// Configuration writes take effect at once and belong between items.
module smoothed_duty_waveform_sampler_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [sdws_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [sdws_pkg::DATA_W-1:0]           wr_data,
  input  logic                                  index_valid,
  output logic                                  index_stall,
  input  logic [sdws_pkg::INDEX_W-1:0]          sample_index,
  output logic                                  value_valid,
  input  logic                                  value_stall,
  output logic signed [sdws_pkg::OUT_W-1:0]     sample_value
);
  import sdws_pkg::*;

  localparam int UP_W = DUTY_W + POS_W;
  localparam int ST_W = PHASE_W + POS_W;

  logic signed [AMP_W-1:0] amplitude;
  logic [DUTY_W-1:0]       duty_fraction;
  logic [PHASE_W-1:0]      phase_fraction;

  state_t state, state_next;

  logic [INDEX_W-1:0] idx_q;
  logic [POS_W-1:0]   tap_pos, tap_pos_next;
  logic [CNT_W-1:0]   tap_cnt;
  logic [TAP_W-1:0]   tap_w;

  logic [UP_W-1:0]    up_prod;
  logic [POS_W:0]     up_raw;
  logic [POS_W-1:0]   up;
  logic [ST_W-1:0]    start_prod;
  logic [POS_W-1:0]   start;
  logic [POS_W-1:0]   j_pos;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos;
  logic [POS_W:0]     first_sum;
  logic [POS_W-1:0]   first_pos;

  acc_ctl_t                ctl;
  logic signed [ACC_W-1:0] acc;
  logic signed [OUT_W-1:0] rounded;
  logic                    load_prod;
  logic                    load_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude      <= AMP_RESET;
      duty_fraction  <= DUTY_RESET;
      phase_fraction <= PHASE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_AMPLITUDE: amplitude      <= signed'(wr_data[AMP_W-1:0]);
        REG_DUTY:      duty_fraction  <= wr_data[DUTY_W-1:0];
        REG_PHASE:     phase_fraction <= wr_data[PHASE_W-1:0];
        default:       ;
      endcase
    end
  end

  // high length and rotation of the period
  always_comb begin
    up_prod    = UP_W'(duty_fraction) * UP_W'(PERIOD_SAMPLES);
    up_raw     = up_prod[UP_W-1:FRAC_BITS];
    // duty above one: hold the wave high over the whole period
    up         = (up_raw > (POS_W+1)'(PERIOD_SAMPLES)) ? POS_W'(PERIOD_SAMPLES)
                                                      : up_raw[POS_W-1:0];
    start_prod = ST_W'(phase_fraction) * ST_W'(PERIOD_SAMPLES);
    start      = start_prod[ST_W-1:FRAC_BITS];
  end

  // position of the first tap: index wrapped, rotated, minus the half-width
  always_comb begin
    j_pos     = (idx_q >= INDEX_W'(PERIOD_SAMPLES)) ? POS_W'(idx_q - INDEX_W'(PERIOD_SAMPLES))
                                                    : POS_W'(idx_q);
    pos_sum   = (POS_W+1)'(j_pos) + (POS_W+1)'(start);
    pos       = (pos_sum >= (POS_W+1)'(PERIOD_SAMPLES))
                ? POS_W'(pos_sum - (POS_W+1)'(PERIOD_SAMPLES)) : POS_W'(pos_sum);
    first_sum = (POS_W+1)'(pos) + (POS_W+1)'(PERIOD_SAMPLES - HALF_W);
    first_pos = (first_sum >= (POS_W+1)'(PERIOD_SAMPLES))
                ? POS_W'(first_sum - (POS_W+1)'(PERIOD_SAMPLES)) : POS_W'(first_sum);
  end

  always_comb begin
    tap_pos_next = (tap_pos == POS_W'(PERIOD_SAMPLES - 1)) ? '0 : tap_pos + 1'b1;
    tap_w        = (tap_cnt < CNT_W'(HALF_W)) ? TAP_W'(CNT_W'(HALF_W) - tap_cnt)
                                              : TAP_W'(tap_cnt - CNT_W'(HALF_W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    load_prod  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (index_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        ctl.clear  = 1'b1;
        state_next = ST_TAP;
      end
      ST_TAP: begin
        ctl.step = 1'b1;
        ctl.high = (tap_pos < up);
        ctl.tap  = tap_w;
        if (tap_cnt == CNT_W'(TAP_LAST)) state_next = ST_MUL;
      end
      ST_MUL: begin
        load_prod  = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        // hold until the output slot is free
        if (!value_valid || !value_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign index_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && index_valid) begin
      idx_q <= sample_index;
    end
    if (state == ST_SETUP) begin
      tap_pos <= first_pos;
      tap_cnt <= '0;
    end else if (state == ST_TAP) begin
      tap_pos <= tap_pos_next;
      tap_cnt <= tap_cnt + 1'b1;
    end
  end

  sdws_accum u_accum (
    .clk (clk),
    .ctl (ctl),
    .acc (acc)
  );

  sdws_scale u_scale (
    .clk     (clk),
    .load    (load_prod),
    .amp     (amplitude),
    .acc     (acc),
    .rounded (rounded)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (load_out) begin
      value_valid <= 1'b1;
    end else if (!value_stall) begin
      value_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_value <= rounded;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    index_valid && !index_stall |=> index_stall)
    else $error("index accepted while block stays ready");

  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> (acc <= WEIGHT_SUM) && (acc >= -WEIGHT_SUM))
    else $error("window sum out of range");

  a_load_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(value_valid) |-> $past(state == ST_RND))
    else $error("result beat raised outside the round step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_stall |-> !load_out)
    else $error("waiting result overwritten");

endmodule

// ===== test/tb_smoothed_duty_waveform_sampler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the smoothed duty waveform sampler
// Builds its own Gaussian window and predicts every smoothed sample from the
// current amplitude, duty and phase. Directed tests cover the register and
// index extremes; random phases then sweep settings, with random gaps on both
// sides of the handshake.
// ----------------------------------------------------------------------------
module tb_smoothed_duty_waveform_sampler_top;
  import sdws_pkg::*;

  localparam int PERIOD = PERIOD_SAMPLES;
  localparam int HALF   = PERIOD / 10;
  localparam int SPREAD = HALF / 3;
  localparam logic [63:0] Q30 = 64'd1 << 30;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                        clk;
  logic                        rst;
  logic                        wr_en;
  logic [REG_IDX_W-1:0]        wr_index;
  logic [DATA_W-1:0]           wr_data;
  logic                        index_valid;
  logic                        index_stall;
  logic [INDEX_W-1:0]          sample_index;
  logic                        value_valid;
  logic                        value_stall = 1'b0;
  logic signed [OUT_W-1:0]     sample_value;

  // Shadow of the configuration and the window
  logic signed [AMP_W-1:0]     amp_q;
  logic [DUTY_W-1:0]           duty_q;
  logic [PHASE_W-1:0]          phase_q;
  longint                      window_tap [0:HALF];

  logic signed [OUT_W-1:0]     pending_samples [$];
  logic signed [OUT_W-1:0]     want_sample;
  int                          mismatch_count = 0;
  bit                          quiet_run = 1'b0;

  smoothed_duty_waveform_sampler_top dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .index_valid  (index_valid),
    .index_stall  (index_stall),
    .sample_index (sample_index),
    .value_valid  (value_valid),
    .value_stall  (value_stall),
    .sample_value (sample_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Truncated Taylor series of exp(-u), u and result in Q30
  function automatic logic [63:0] exp_taylor(input logic [63:0] u);
    longint      acc;
    logic [63:0] term;
    acc  = longint'(Q30);
    term = Q30;
    for (int k = 1; k <= 14; k++) begin
      term = (term * u) / (64'(k) * Q30);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] x);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] e1;
    logic [63:0] r;
    whole = x >> 16;
    frac  = (x & 64'hFFFF) << 14;
    if (whole >= 64'd24) return 64'd0;
    e1 = exp_taylor(Q30);
    r  = exp_taylor(frac);
    for (int i = 0; i < int'(whole); i++) r = (r * e1 + (64'd1 << 29)) >> 30;
    return r;
  endfunction

  function automatic void build_window();
    logic [63:0] raw [0:HALF];
    logic [63:0] total;
    logic [63:0] x;
    total = 0;
    if (SPREAD == 0) begin
      for (int d = 0; d <= HALF; d++) window_tap[d] = 0;
      window_tap[0] = 32768;
      return;
    end
    for (int d = 0; d <= HALF; d++) begin
      x = (64'(d * d) * 64'd65536) / (64'd2 * 64'(SPREAD) * 64'(SPREAD));
      raw[d] = exp_neg(x);
      total += (d == 0) ? raw[d] : 2 * raw[d];
    end
    for (int d = 0; d <= HALF; d++)
      window_tap[d] = longint'((raw[d] * 64'd32768 + total / 2) / total);
  endfunction

  function automatic logic signed [OUT_W-1:0] smoothed_sample(input logic [INDEX_W-1:0] idx);
    longint up;
    longint start;
    longint pos;
    longint p;
    longint acc;
    longint prod;
    longint mag;
    longint r;
    up    = (longint'(PERIOD) * longint'(duty_q)) >>> 16;
    start = ((longint'(PERIOD) * longint'(phase_q)) >>> 16) % PERIOD;
    pos   = ((longint'(idx) % PERIOD) + start) % PERIOD;
    if (up > PERIOD) up = PERIOD;
    acc = 0;
    for (int t = -HALF; t <= HALF; t++) begin
      p = (pos + t + PERIOD) % PERIOD;
      acc += (p < up) ? window_tap[t < 0 ? -t : t] : -window_tap[t < 0 ? -t : t];
    end
    prod = longint'(amp_q) * acc;
    mag  = (prod < 0) ? -prod : prod;
    r    = (mag + 16384) >>> 15;
    if (prod < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  // Send one index beat; valid stays high for a following beat
  task automatic send_index(input logic [INDEX_W-1:0] idx);
    while (!quiet_run && $urandom_range(0, 99) < 14) begin
      index_valid <= 1'b0;
      @(posedge clk);
    end
    index_valid  <= 1'b1;
    sample_index <= idx;
    do @(posedge clk); while (index_stall);
    pending_samples = {pending_samples, smoothed_sample(idx)};
  endtask

  task automatic wait_drained();
    index_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves wr_en high; the caller drops it after the last write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_AMPLITUDE: amp_q   = data[AMP_W-1:0];
      REG_DUTY:      duty_q  = data;
      REG_PHASE:     phase_q = data[PHASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [DATA_W-1:0] amp, input logic [DATA_W-1:0] duty,
                            input logic [DATA_W-1:0] phase);
    wait_drained();
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_DUTY, duty);
    write_reg(REG_PHASE, phase);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_index(7'd0);
    send_index(7'd1);
    send_index(7'd99);
    send_index(7'd127);
  endtask

  task automatic test_duty_extremes();
    set_config(17'd4096, 17'd0, 17'd0);
    send_index(7'd0);
    send_index(7'd50);
    set_config(17'd4096, 17'd65536, 17'd0);
    send_index(7'd10);
    send_index(7'd100);
    // duty above one: the wave stays high
    set_config(17'h0_8001, 17'h1FFFF, 17'd65535);
    send_index(7'd99);
    send_index(7'd64);
    set_config(17'd12345, 17'd1, 17'd65535);
    send_index(7'd0);
  endtask

  task automatic test_amplitude_saturation();
    set_config(17'd32767, 17'd65536, 17'd0);
    send_index(7'd42);
    set_config(17'h0_8000, 17'd0, 17'd0);
    send_index(7'd17);
    set_config(17'h0_FFFF, 17'd30000, 17'd20000);
    send_index(7'd33);
  endtask

  task automatic test_register_decode();
    wait_drained();
    // unknown index: nothing changes
    write_reg(REG_UNUSED, 17'h1FFFF);
    wr_en <= 1'b0;
    send_index(7'd3);
    wait_drained();
    // amplitude takes the low sixteen bits only
    write_reg(REG_AMPLITUDE, 17'h1_2345);
    wr_en <= 1'b0;
    send_index(7'd80);
  endtask

  task automatic test_drained_singles();
    set_config(17'd20000, 17'd45000, 17'd9000);
    for (int i = 0; i < 6; i++) begin
      send_index(7'($urandom_range(0, 127)));
      wait_drained();
    end
  endtask

  task automatic test_random_phases();
    logic [DATA_W-1:0] amp;
    logic [DATA_W-1:0] duty;
    logic [DATA_W-1:0] phase;
    for (int ph = 0; ph < 18; ph++) begin
      case ($urandom_range(0, 5))
        0:       amp = 17'h0_8000;
        1:       amp = 17'd32767;
        2:       amp = 17'd0;
        default: amp = 17'($urandom_range(0, 131071));
      endcase
      case ($urandom_range(0, 6))
        0:       duty = 17'd0;
        1:       duty = 17'd65536;
        2:       duty = 17'($urandom_range(65537, 131071));
        default: duty = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 5))
        0:       phase = 17'd0;
        1:       phase = 17'd65535;
        default: phase = 17'($urandom_range(0, 131071));
      endcase
      set_config(amp, duty, phase);
      quiet_run = (ph == 6);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 4) == 0) send_index(7'($urandom_range(0, 127)));
        else send_index(7'($urandom_range(0, PERIOD - 1)));
        // hold off now and then until every sample is back
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
      quiet_run = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    value_stall <= !quiet_run && ($urandom_range(0, 99) < 14);
  end

  always @(posedge clk) begin
    if (!rst && value_valid && !value_stall) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: sample_value expected none, actual %0d", $time, sample_value);
        mismatch_count++;
      end else begin
        want_sample = pending_samples.pop_front();
        if (sample_value !== want_sample) begin
          $display("%0t: sample_value expected %0d, actual %0d", $time, want_sample,
                   sample_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    wr_en        <= 1'b0;
    wr_index     <= REG_AMPLITUDE;
    wr_data      <= '0;
    index_valid  <= 1'b0;
    sample_index <= '0;
    amp_q   = AMP_RESET;
    duty_q  = DUTY_RESET;
    phase_q = PHASE_RESET;
    build_window();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_duty_extremes();
    test_amplitude_saturation();
    test_register_decode();
    test_drained_singles();
    test_random_phases();

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== smoothed_duty_waveform_sampler_top.f =====
sv/sdws_pkg.sv
sv/sdws_accum.sv
sv/sdws_scale.sv
sv/smoothed_duty_waveform_sampler_top.sv
test/tb_smoothed_duty_waveform_sampler_top.sv
